// ----- rtl/sfd_pkg.sv -----
// SLIP frame decoder package: byte codes, result kinds and the payload types.
// Used by the result channel interface and the decoder top level; depends on nothing.
package sfd_pkg;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam int unsigned LEN_W = 9;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

endpackage

// ----- rtl/sfd_in_if.sv -----
// Receive channel of the SLIP decoder: one serial-line byte and its fault flag per word.
// Depends on nothing.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_fault;

  modport source (output valid, output rx_byte, output line_fault, input ready);
  modport sink   (input valid, input rx_byte, input line_fault, output ready);
endinterface

// ----- rtl/sfd_out_if.sv -----
// Result channel of the SLIP decoder: one decoded result per received word.
// Depends on sfd_pkg for the result kind type and length width.
interface sfd_out_if;
  logic                        valid;
  logic                        ready;
  sfd_pkg::kind_t              kind;
  logic [7:0]                  data_byte;
  logic [sfd_pkg::LEN_W-1:0]   frame_length;
  logic                        malformed;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  output malformed, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  input malformed, output ready);
endinterface

// ----- rtl/slip_frame_decoder.sv -----
// SLIP frame decoder top level: input register, decode step and result register.
// Depends on sfd_pkg, sfd_in_if and sfd_out_if.
//
//   channel  dir  payload                                        handshake
//   rx       in   rx_byte[7:0], line_fault                       valid/ready
//   dec      out  kind[1:0], data_byte[7:0], frame_length[8:0],  valid/ready
//                 malformed
//
// One word in and one result out per cycle while dec is ready; a word passes the input
// register, then the decode step into the result register.
// Synchronous reset leaves the decoder unsynchronised, no escape, empty frame.
// A stalled result holds the decode stage; rx keeps accepting while the input
// register is free or moving on.
module slip_frame_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst,
  sfd_in_if.sink           rx,
  sfd_out_if.source        dec
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_fault;

  // decoder state
  logic          in_sync, in_sync_next;
  logic          escape_pending, escape_pending_next;
  logic [CW-1:0] frame_count, frame_count_next;

  // result register
  logic                      out_valid;
  sfd_pkg::kind_t            kind, kind_next;
  logic [7:0]                data_byte, data_byte_next;
  logic [sfd_pkg::LEN_W-1:0] frame_length, frame_length_next;
  logic                      malformed, malformed_next;

  logic advance;
  logic room;
  logic [7:0] decoded;

  assign advance  = !out_valid || dec.ready;
  assign rx.ready = !s1_valid || advance;
  assign room     = frame_count < MAX_COUNT;

  always_comb begin
    in_sync_next        = in_sync;
    escape_pending_next = escape_pending;
    frame_count_next    = frame_count;
    kind_next           = sfd_pkg::KIND_NONE;
    data_byte_next      = 8'd0;
    frame_length_next   = '0;
    malformed_next      = 1'b0;
    decoded             = s1_byte;

    if (s1_fault) begin
      in_sync_next = 1'b0;
    end else if (!in_sync) begin
      // wait for END to regain sync
      if (s1_byte == sfd_pkg::SLIP_END) begin
        in_sync_next        = 1'b1;
        escape_pending_next = 1'b0;
        frame_count_next    = '0;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      case (s1_byte)
        sfd_pkg::SLIP_ESC_END: decoded = sfd_pkg::SLIP_END;
        sfd_pkg::SLIP_ESC_ESC: decoded = sfd_pkg::SLIP_ESC;
        default:               malformed_next = 1'b1;
      endcase
      if (room) begin
        frame_count_next = frame_count + 1'b1;
        kind_next        = sfd_pkg::KIND_DATA;
        data_byte_next   = decoded;
      end
    end else if (s1_byte == sfd_pkg::SLIP_END) begin
      if (frame_count != '0) begin
        frame_count_next  = '0;
        kind_next         = sfd_pkg::KIND_END;
        frame_length_next = sfd_pkg::LEN_W'(frame_count);
      end
    end else if (s1_byte == sfd_pkg::SLIP_ESC) begin
      escape_pending_next = 1'b1;
    end else if (room) begin
      frame_count_next = frame_count + 1'b1;
      kind_next        = sfd_pkg::KIND_DATA;
      data_byte_next   = s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      in_sync        <= 1'b0;
      escape_pending <= 1'b0;
      frame_count    <= '0;
    end else begin
      if (rx.ready) begin
        s1_valid <= rx.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      // commit state only when the word actually moves into the result register
      if (advance && s1_valid) begin
        in_sync        <= in_sync_next;
        escape_pending <= escape_pending_next;
        frame_count    <= frame_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte  <= rx.rx_byte;
      s1_fault <= rx.line_fault;
    end
    if (advance && s1_valid) begin
      kind         <= kind_next;
      data_byte    <= data_byte_next;
      frame_length <= frame_length_next;
      malformed    <= malformed_next;
    end
  end

  assign dec.valid        = out_valid;
  assign dec.kind         = kind;
  assign dec.data_byte    = data_byte;
  assign dec.frame_length = frame_length;
  assign dec.malformed    = malformed;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= MAX_COUNT)
    else $error("frame count past capacity");

  a_fault_gives_none: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_fault) |=>
      (out_valid && kind == sfd_pkg::KIND_NONE && !malformed))
    else $error("faulted word produced a result");

  a_fault_drops_sync: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_fault) |=> !in_sync)
    else $error("sync kept after line fault");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == sfd_pkg::KIND_END) |-> (data_byte == 8'd0 && !malformed))
    else $error("frame end carries data");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |=> s1_valid)
    else $error("accepted word lost from input register");
`endif

endmodule
